// File: hdl/icfe_pkg.sv
// ----------------------------------------------------------------------------
// icfe_pkg
// shared types and constants for the wolff cluster flip engine
// ----------------------------------------------------------------------------
package icfe_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int SITE_W = 2 * COORD_W;
  localparam int SITES = MAX_SIDE * MAX_SIDE;
  localparam int DEPTH_W = SITE_W + 1;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_CLUSTER = 2'd2;

  localparam logic [1:0] REG_SIDE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_RDSITE,
    ST_RDWAIT,
    ST_START,
    ST_TOP,
    ST_TOPWAIT,
    ST_NBR,
    ST_NBRWAIT,
    ST_TEST,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;        // lattice clearing pass after reset
    logic latch_in;     // capture the input word
    logic reduce;       // wrap coordinates into the side in use
    logic flip_start;   // flip start site, push it
    logic step_top;     // advance/pop top frame, issue neighbour read
    logic rd_nbr;       // hold neighbour address on the lattice read port
    logic test_nbr;     // draw and maybe join neighbour
    logic write_site;   // func write
    logic finish;       // emit result
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic stack_empty;
    logic clear_done;
    logic coord_ok;
  } status_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

// File: hdl/icfe_ctrl.sv
// ----------------------------------------------------------------------------
// icfe_ctrl
// sequencer for site access and the depth-first cluster walk
// ----------------------------------------------------------------------------
module icfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  icfe_pkg::status_t  status,
  output icfe_pkg::cmd_t     cmd,
  output logic               busy
);

  icfe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icfe_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      icfe_pkg::ST_CLEAR: begin
        if (status.clear_done) state_next = icfe_pkg::ST_IDLE;
      end
      icfe_pkg::ST_IDLE: begin
        if (start) state_next = icfe_pkg::ST_REDUCE;
      end
      icfe_pkg::ST_REDUCE: begin
        if (status.coord_ok) state_next = icfe_pkg::ST_RDSITE;
      end
      icfe_pkg::ST_RDSITE: state_next = icfe_pkg::ST_RDWAIT;
      icfe_pkg::ST_RDWAIT: begin
        if (status.func == icfe_pkg::FUNC_CLUSTER) state_next = icfe_pkg::ST_START;
        else state_next = icfe_pkg::ST_DONE;
      end
      icfe_pkg::ST_START: state_next = icfe_pkg::ST_TOP;
      icfe_pkg::ST_TOP: begin
        if (status.stack_empty) state_next = icfe_pkg::ST_DONE;
        else state_next = icfe_pkg::ST_TOPWAIT;
      end
      icfe_pkg::ST_TOPWAIT: state_next = icfe_pkg::ST_NBR;
      icfe_pkg::ST_NBR: state_next = icfe_pkg::ST_NBRWAIT;
      icfe_pkg::ST_NBRWAIT: state_next = icfe_pkg::ST_TEST;
      icfe_pkg::ST_TEST: state_next = icfe_pkg::ST_TOP;
      icfe_pkg::ST_DONE: state_next = icfe_pkg::ST_IDLE;
      default: state_next = icfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      icfe_pkg::ST_CLEAR: cmd.clear = 1'b1;
      icfe_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.latch_in = start;
      end
      icfe_pkg::ST_REDUCE: cmd.reduce = 1'b1;
      icfe_pkg::ST_RDWAIT: cmd.write_site = (status.func == icfe_pkg::FUNC_WRITE);
      icfe_pkg::ST_START: cmd.flip_start = 1'b1;
      icfe_pkg::ST_NBR: cmd.step_top = 1'b1;
      icfe_pkg::ST_NBRWAIT: cmd.rd_nbr = 1'b1;
      icfe_pkg::ST_TEST: cmd.test_nbr = 1'b1;
      icfe_pkg::ST_DONE: cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/icfe_datapath.sv
// ----------------------------------------------------------------------------
// icfe_datapath
// lattice and stack memories, generator, neighbour address and counters
// ----------------------------------------------------------------------------
module icfe_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  icfe_pkg::cmd_t                  cmd,
  output icfe_pkg::status_t               status,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic [1:0]                      func,
  input  logic [icfe_pkg::COORD_W-1:0]    site_row,
  input  logic [icfe_pkg::COORD_W-1:0]    site_col,
  input  logic                            spin_in,
  output logic                            done,
  output logic [12:0]                     cluster_size,
  output logic                            spin_out
);

  localparam int CW = icfe_pkg::COORD_W;
  localparam int SW = icfe_pkg::SITE_W;
  localparam int DW = icfe_pkg::DEPTH_W;

  // configuration
  logic [6:0] side_reg;
  logic [16:0] thr_reg;
  logic [31:0] gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg <= 7'd50;
      thr_reg <= 17'd58016;
    end else if (cfg_we) begin
      if (cfg_index == icfe_pkg::REG_SIDE) side_reg <= cfg_data[6:0];
      if (cfg_index == icfe_pkg::REG_THRESHOLD) thr_reg <= cfg_data[16:0];
    end
  end

  // clamped side, minus one, as CW bits
  logic [CW-1:0] side_m1;
  always_comb begin
    if (side_reg < 7'd2) side_m1 = CW'(1);
    else if (side_reg > 7'(icfe_pkg::MAX_SIDE)) side_m1 = CW'(icfe_pkg::MAX_SIDE - 1);
    else side_m1 = CW'(side_reg - 7'd1);
  end

  // latched input; coordinates wrapped into the side by repeated subtract
  logic [1:0] func_q;
  logic spin_q;
  logic [CW:0] row_q, col_q;
  logic [CW:0] side_w;
  assign side_w = {1'b0, side_m1} + (CW+1)'(1);

  // lattice, set to all +1 by the clearing pass after reset
  logic lat_mem [icfe_pkg::SITES];
  logic lat_rd;
  logic [SW-1:0] lat_raddr;
  logic lat_we;
  logic [SW-1:0] lat_waddr;
  logic lat_wdata;
  logic spin_rd;
  logic [SW-1:0] clr_addr;
  assign spin_rd = lat_rd;

  // stack memory
  logic [SW+1:0] stk_mem [icfe_pkg::SITES];
  logic [SW+1:0] stk_rd;
  logic stk_we;
  logic [SW-1:0] stk_waddr;
  logic [SW+1:0] stk_wdata;
  logic [DW-1:0] depth;

  logic center;
  logic [12:0] size;
  logic [SW-1:0] nbr;

  // neighbour of stack top
  logic [CW-1:0] r, c, nr, nc;
  always_comb begin
    r = stk_rd[SW+1:CW+2];
    c = stk_rd[CW+1:2];
    nr = r;
    nc = c;
    case (stk_rd[1:0])
      2'd0: nr = (r == '0) ? side_m1 : r - CW'(1);
      2'd1: nr = (r == side_m1) ? '0 : r + CW'(1);
      2'd2: nc = (c == '0) ? side_m1 : c - CW'(1);
      default: nc = (c == side_m1) ? '0 : c + CW'(1);
    endcase
  end

  logic [31:0] gen_next;
  assign gen_next = icfe_pkg::xorshift(gen);
  logic joins;
  assign joins = (spin_rd == center) && ({1'b0, gen_next[31:16]} < thr_reg);

  logic [SW-1:0] start_addr;
  assign start_addr = {row_q[CW-1:0], col_q[CW-1:0]};

  always_comb begin
    lat_raddr = start_addr;
    if (cmd.step_top) lat_raddr = {nr, nc};
    else if (cmd.rd_nbr) lat_raddr = nbr;
    lat_we = 1'b0;
    lat_waddr = start_addr;
    lat_wdata = spin_q;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = {start_addr, 2'd0};
    if (cmd.clear) begin
      lat_we = 1'b1;
      lat_waddr = clr_addr;
      lat_wdata = 1'b1;
    end else if (cmd.write_site) begin
      lat_we = 1'b1;
    end else if (cmd.flip_start) begin
      lat_we = 1'b1;
      lat_wdata = ~spin_rd;
      stk_we = 1'b1;
    end else if (cmd.step_top) begin
      stk_we = (stk_rd[1:0] != 2'd3);
      stk_waddr = SW'(depth - DW'(1));
      stk_wdata = {stk_rd[SW+1:2], stk_rd[1:0] + 2'd1};
    end else if (cmd.test_nbr && joins) begin
      lat_we = 1'b1;
      lat_waddr = nbr;
      lat_wdata = ~center;
      stk_we = 1'b1;
      stk_waddr = SW'(depth);
      stk_wdata = {nbr, 2'd0};
    end
  end

  always_ff @(posedge clk) begin
    lat_rd <= lat_mem[lat_raddr];
    if (lat_we) lat_mem[lat_waddr] <= lat_wdata;
    stk_rd <= stk_mem[SW'(depth - DW'(1))];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= 32'd1;
      depth <= '0;
      done <= 1'b0;
      func_q <= '0;
      clr_addr <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear) clr_addr <= clr_addr + SW'(1);
      if (cfg_we && cfg_index == icfe_pkg::REG_SEED) begin
        gen <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
      end else if (cmd.test_nbr && spin_rd == center) begin
        gen <= gen_next;
      end
      if (cmd.latch_in) func_q <= func;
      if (cmd.flip_start) depth <= DW'(1);
      else if (cmd.step_top && stk_rd[1:0] == 2'd3) begin
        if (cmd.test_nbr) depth <= depth;
        else depth <= depth - DW'(1);
      end else if (cmd.test_nbr && joins) depth <= depth + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      spin_q <= spin_in;
      row_q <= {1'b0, site_row};
      col_q <= {1'b0, site_col};
    end
    // one subtract per cycle until both coordinates are inside the side
    if (cmd.reduce) begin
      if (row_q >= side_w) row_q <= row_q - side_w;
      if (col_q >= side_w) col_q <= col_q - side_w;
    end
    if (cmd.flip_start) begin
      center <= spin_rd;
      size <= 13'd1;
    end
    if (cmd.step_top) nbr <= {nr, nc};
    if (cmd.test_nbr && joins) size <= size + 13'd1;
    if (cmd.finish) begin
      cluster_size <= (func_q == icfe_pkg::FUNC_CLUSTER) ? size : 13'd0;
      spin_out <= (func_q == icfe_pkg::FUNC_READ) ? spin_rd : 1'b0;
    end
  end

  assign status.func = func_q;
  assign status.stack_empty = (depth == '0);
  assign status.clear_done = (clr_addr == SW'(icfe_pkg::SITES - 1));
  assign status.coord_ok = (row_q < side_w) && (col_q < side_w);

endmodule

// File: hdl/ising_cluster_flip_engine_core.sv
// ----------------------------------------------------------------------------
// ising_cluster_flip_engine_core
// wolff cluster update engine on a periodic 2d ising lattice
// ----------------------------------------------------------------------------
// sequence: write, read and unused func latch the word, wrap the site into the side
// by repeated subtract, read the site and finish; a cluster update also flips the
// start site and runs 4 neighbour tests per flipped site before it finishes
// throughput: one word at a time, next start accepted in the done cycle
// reset: sync active high; clear of the lattice to +1 with busy high,
// seed 1, side 50, threshold 58016; done strobes one cycle, receiver cannot stall
module ising_cluster_flip_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [5:0]  site_row,
  input  logic [5:0]  site_col,
  input  logic        spin_in,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [12:0] cluster_size,
  output logic        spin_out
);

  icfe_pkg::cmd_t cmd;
  icfe_pkg::status_t status;
  logic ctrl_busy;

  icfe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .busy(ctrl_busy)
  );

  icfe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .site_row(site_row), .site_col(site_col), .spin_in(spin_in),
    .done(done), .cluster_size(cluster_size), .spin_out(spin_out)
  );

  assign busy = ctrl_busy;

endmodule

// File: hdl/icfe_checker.sv
// ----------------------------------------------------------------------------
// icfe_checker
// port-level checks for the cluster flip engine
// ----------------------------------------------------------------------------
module icfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [12:0] cluster_size,
  input logic        spin_out
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    done |-> (cluster_size == 13'd0 || !spin_out)) else $error("both result fields set");

endmodule

bind ising_cluster_flip_engine_core icfe_checker u_icfe_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cluster_size(cluster_size), .spin_out(spin_out)
);

// File: verif/ising_cluster_flip_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_cluster_flip_engine_core_test
// self-checking bench for the wolff cluster flip engine: site writes, reads
// and cluster updates are driven through the start/busy port in random bursts
// while a lattice predictor walks each cluster and checks every done word
// ----------------------------------------------------------------------------
module ising_cluster_flip_engine_core_test;

  localparam int IDLE_LIMIT = 400000;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic       spin;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = icfe_pkg::FUNC_WRITE;
  logic [5:0]  site_row = '0;
  logic [5:0]  site_col = '0;
  logic        spin_in = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = icfe_pkg::REG_SIDE;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [12:0] cluster_size;
  logic        spin_out;

  ising_cluster_flip_engine_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic        lattice [icfe_pkg::SITES];
  int          walk_site [icfe_pkg::SITES];
  int          walk_dir [icfe_pkg::SITES];
  logic [6:0]  side_q = 7'd50;
  logic [16:0] thresh_q = 17'd58016;
  logic [31:0] rng_q = 32'd1;

  word_t       pending_words [$];
  logic [12:0] size_expected [$];
  logic        spin_expected [$];

  int errors = 0;
  int words_sent = 0;
  int clusters_run = 0;
  int sites_flipped = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  logic took = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int eff_side();
    if (side_q < 2) return 2;
    if (side_q > icfe_pkg::MAX_SIDE) return icfe_pkg::MAX_SIDE;
    return side_q;
  endfunction

  function automatic int flip_cluster(input int first, input int side);
    int thr, sz, depth, d, r, c, n;
    logic center;
    logic [31:0] x;
    thr = (thresh_q > 65536) ? 65536 : thresh_q;
    center = lattice[first];
    lattice[first] = ~center;
    sz = 1;
    walk_site[0] = first;
    walk_dir[0] = 0;
    depth = 1;
    while (depth > 0) begin
      d = walk_dir[depth-1];
      r = walk_site[depth-1] / icfe_pkg::MAX_SIDE;
      c = walk_site[depth-1] % icfe_pkg::MAX_SIDE;
      case (d)
        0: r = (r == 0) ? side - 1 : r - 1;
        1: r = (r + 1 == side) ? 0 : r + 1;
        2: c = (c == 0) ? side - 1 : c - 1;
        default: c = (c + 1 == side) ? 0 : c + 1;
      endcase
      n = r * icfe_pkg::MAX_SIDE + c;
      if (d >= 3) depth--;
      else walk_dir[depth-1] = d + 1;
      if (lattice[n] == center) begin
        // draw only for matching neighbours
        x = rng_q;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng_q = x;
        if (int'(x[31:16]) < thr) begin
          lattice[n] = ~center;
          sz++;
          walk_site[depth] = n;
          walk_dir[depth] = 0;
          depth++;
        end
      end
    end
    return sz;
  endfunction

  task automatic predict(input word_t w);
    int side, site, sz;
    logic so;
    side = eff_side();
    site = (int'(w.row) % side) * icfe_pkg::MAX_SIDE + (int'(w.col) % side);
    sz = 0;
    so = 1'b0;
    case (w.func)
      icfe_pkg::FUNC_WRITE: lattice[site] = w.spin;
      icfe_pkg::FUNC_READ: so = lattice[site];
      icfe_pkg::FUNC_CLUSTER: begin
        sz = flip_cluster(site, side);
        clusters_run++;
        sites_flipped += sz;
      end
      default: ;
    endcase
    size_expected.push_back(sz[12:0]);
    spin_expected.push_back(so);
  endtask

  // driver: words leave at the falling edge, in bursts with gaps
  always @(negedge clk) begin
    logic nx;
    word_t w;
    nx = start;
    if (!rst && (!start || took)) begin
      nx = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        func <= w.func;
        site_row <= w.row;
        site_col <= w.col;
        spin_in <= w.spin;
        nx = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    start <= nx;
  end

  // monitor: checks done words, predicts accepted words, tracks config
  always @(posedge clk) begin
    logic acc;
    acc = start && !busy && !rst;
    took <= acc;
    if (!rst) begin
      if (done) begin
        if (size_expected.size() == 0) begin
          report("unexpected word, cluster_size", cluster_size, -1);
        end else begin
          if (cluster_size !== size_expected[0])
            report("cluster_size", cluster_size, size_expected[0]);
          if (spin_out !== spin_expected[0])
            report("spin_out", spin_out, spin_expected[0]);
          void'(size_expected.pop_front());
          void'(spin_expected.pop_front());
        end
      end
      if (acc) begin
        predict('{func, site_row, site_col, spin_in});
        words_sent++;
      end
      if (cfg_we) begin
        case (cfg_index)
          icfe_pkg::REG_SIDE: side_q = cfg_data[6:0];
          icfe_pkg::REG_THRESHOLD: thresh_q = cfg_data[16:0];
          icfe_pkg::REG_SEED: rng_q = (cfg_data == 0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      idle_cycles = (acc || done) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("[ising_cluster_flip_engine_core] ERROR");
        $finish;
      end
    end
  end

  task automatic settle();
    while (pending_words.size() > 0 || start || size_expected.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] sd, input logic [31:0] th, input logic [31:0] sv);
    settle();
    write_reg(icfe_pkg::REG_SIDE, sd);
    write_reg(icfe_pkg::REG_THRESHOLD, th);
    write_reg(icfe_pkg::REG_SEED, sv);
  endtask

  task automatic add(input logic [1:0] f, input int r, input int c, input logic s);
    pending_words.push_back('{f, r[5:0], c[5:0], s});
  endtask

  function automatic logic [1:0] pick_func();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return icfe_pkg::FUNC_WRITE;
    if (p < 60) return icfe_pkg::FUNC_READ;
    if (p < 95) return icfe_pkg::FUNC_CLUSTER;
    return FUNC_NONE;
  endfunction

  initial begin
    for (int i = 0; i < icfe_pkg::SITES; i++) lattice[i] = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: side 50, wide first cluster over a nearly uniform lattice
    add(icfe_pkg::FUNC_READ, 0, 0, 1'b0);
    add(icfe_pkg::FUNC_WRITE, 63, 63, 1'b0);
    add(icfe_pkg::FUNC_READ, 13, 13, 1'b1);
    add(FUNC_NONE, 63, 0, 1'b1);
    add(icfe_pkg::FUNC_CLUSTER, 0, 0, 1'b1);
    add(icfe_pkg::FUNC_READ, 49, 49, 1'b0);

    // tiny lattice, side below range, threshold above range, zero seed
    set_all(32'd1, 32'h1FFFF, 32'd0);
    add(icfe_pkg::FUNC_WRITE, 1, 1, 1'b1);
    add(icfe_pkg::FUNC_CLUSTER, 0, 0, 1'b0);
    add(icfe_pkg::FUNC_READ, 63, 62, 1'b0);
    add(icfe_pkg::FUNC_CLUSTER, 3, 3, 1'b0);

    // full size lattice from an oversized side, all bonds accepted
    set_all(32'd127, 32'd65536, 32'hFFFFFFFF);
    add(icfe_pkg::FUNC_CLUSTER, 63, 63, 1'b0);
    add(icfe_pkg::FUNC_READ, 63, 0, 1'b0);
    add(icfe_pkg::FUNC_WRITE, 0, 63, 1'b1);

    // no bonds at all: single-site clusters
    set_all(32'd64, 32'd0, 32'h8000_0001);
    add(icfe_pkg::FUNC_CLUSTER, 31, 32, 1'b0);
    add(icfe_pkg::FUNC_CLUSTER, 0, 63, 1'b0);
    add(icfe_pkg::FUNC_READ, 0, 63, 1'b0);

    set_all(32'd2, 32'd32768, 32'h1234_5678);
    add(icfe_pkg::FUNC_WRITE, 0, 1, 1'b0);
    add(icfe_pkg::FUNC_CLUSTER, 0, 1, 1'b0);
    add(icfe_pkg::FUNC_READ, 1, 1, 1'b0);

    // random phases on small lattices
    for (int ph = 0; ph < 6; ph++) begin
      int sd, th;
      sd = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      case ($urandom_range(0, 3))
        0: th = $urandom_range(0, 20000);
        1: th = $urandom_range(40000, 65536);
        default: th = $urandom_range(0, 65536);
      endcase
      set_all(sd, th, $urandom());
      for (int k = 0; k < 20; k++)
        add(pick_func(), $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
    end

    settle();
    repeat (50) @(posedge clk);
    $display("covered %0d words, %0d cluster updates flipping %0d sites",
             words_sent, clusters_run, sites_flipped);
    $display("lattice sides 2 to 64, thresholds 0 to saturated, seeds incl. zero");
    if (errors == 0) begin
      $display("[ising_cluster_flip_engine_core] OK");
    end else begin
      $display("[ising_cluster_flip_engine_core] ERROR");
    end
    $finish;
  end

endmodule
